// File: design/trs_pkg.sv
// Shared types, constants and arithmetic helpers of the TRS world matrix builder.
`timescale 1ns / 1ps

package trs_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int CORDIC_STEPS   = 28;
   localparam int FIELD_W        = 32;
   localparam int ANGLE_W        = 16;
   localparam int TRIG_W         = 18;
   localparam int ROT_W          = 19;
   localparam int XY_W           = 34;
   localparam int Z_W            = 33;
   localparam int MID_DEPTH      = 16;
   localparam int OUT_DEPTH      = 8;
   localparam int LANES          = 3;

   localparam logic signed [XY_W-1:0]    CORDIC_X0 = 34'sd652032874;
   localparam logic signed [TRIG_W-1:0]  TRIG_ONE  = 18'sd65536;
   localparam logic signed [FIELD_W-1:0] Q_ONE     = 32'sd65536;

   typedef struct packed {
      logic signed [FIELD_W-1:0] scale_x;
      logic signed [FIELD_W-1:0] scale_y;
      logic signed [FIELD_W-1:0] scale_z;
      logic [ANGLE_W-1:0]        angle_x;
      logic [ANGLE_W-1:0]        angle_y;
      logic [ANGLE_W-1:0]        angle_z;
      logic signed [FIELD_W-1:0] move_x;
      logic signed [FIELD_W-1:0] move_y;
      logic signed [FIELD_W-1:0] move_z;
   } req_type;

   typedef struct packed {
      logic [1:0]                row_index;
      logic signed [FIELD_W-1:0] elem_0;
      logic signed [FIELD_W-1:0] elem_1;
      logic signed [FIELD_W-1:0] elem_2;
      logic signed [FIELD_W-1:0] elem_3;
      logic                      last_row;
   } rsp_type;

   // Rotation matrix plus the per-row scale and the translation row
   typedef struct packed {
      logic signed [FIELD_W-1:0] scale_x;
      logic signed [FIELD_W-1:0] scale_y;
      logic signed [FIELD_W-1:0] scale_z;
      logic signed [FIELD_W-1:0] move_x;
      logic signed [FIELD_W-1:0] move_y;
      logic signed [FIELD_W-1:0] move_z;
      logic signed [ROT_W-1:0]   r00;
      logic signed [ROT_W-1:0]   r01;
      logic signed [ROT_W-1:0]   r02;
      logic signed [ROT_W-1:0]   r10;
      logic signed [ROT_W-1:0]   r11;
      logic signed [ROT_W-1:0]   r12;
      logic signed [ROT_W-1:0]   r20;
      logic signed [ROT_W-1:0]   r21;
      logic signed [ROT_W-1:0]   r22;
   } rot_type;

   // Arctangent of 2^-i in units of 2^32 per turn
   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         5'd24: r = 32'd41;
         5'd25: r = 32'd20;
         5'd26: r = 32'd10;
         5'd27: r = 32'd5;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   // Q2.16 product of two unit-range values, rounded half up
   function automatic logic signed [TRIG_W-1:0] qmul_trig(input logic signed [TRIG_W-1:0] a,
                                                         input logic signed [TRIG_W-1:0] b);
      logic signed [2*TRIG_W-1:0] p;
      p = (2*TRIG_W)'(a) * (2*TRIG_W)'(b);
      p = p + (2*TRIG_W)'(32768);
      return TRIG_W'(p >>> 16);
   endfunction

endpackage

// File: design/trs_queue.sv
// Small first-in first-out queue with show-ahead head; room is guaranteed by the writer's credits.
`timescale 1ns / 1ps

module trs_queue import trs_pkg::*; #(
   parameter type T     = logic,
   parameter int  DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  T     push_data,
   input  logic pop,
   output T     head,
   output logic empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   T              mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_pop;

   assign empty  = (count_ff == '0);
   assign do_pop = pop && !empty;
   assign head   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/trs_front.sv
// Front end: accepts transforms, runs pipelined CORDIC sine/cosine and builds the rotation matrix.
`timescale 1ns / 1ps

module trs_front import trs_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type req_data,
   output logic    full,
   input  logic    mid_pop,
   output logic    mid_push,
   output rot_type mid_data
);

   localparam int          N     = CORDIC_STEPS;
   localparam int          CW    = $clog2(MID_DEPTH + 1);
   localparam int          PSH   = 32 - ANGLE_BITS;
   localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

   logic [CW-1:0] cred_ff, cred_in;
   logic          accept;

   logic                   vld_ff [0:N];
   req_type                pay_ff [0:N];
   logic [1:0]             quad_ff [0:N][LANES];
   logic signed [XY_W-1:0] x_ff [0:N][LANES];
   logic signed [XY_W-1:0] y_ff [0:N][LANES];
   logic signed [Z_W-1:0]  z_ff [0:N][LANES];

   logic [ANGLE_W-1:0] ang [LANES];

   // Credits cover every item in the pipeline and in the queue behind it
   assign full   = (cred_ff == CW'(MID_DEPTH));
   assign accept = push && !full;

   always_comb begin
      cred_in = cred_ff + CW'(accept) - CW'(mid_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cred_ff <= '0;
      end else begin
         cred_ff <= cred_in;
      end
   end

   assign ang[0] = req_data.angle_x;
   assign ang[1] = req_data.angle_y;
   assign ang[2] = req_data.angle_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
      end
   end

   always_ff @(posedge clock) begin
      pay_ff[0] <= req_data;
   end

   genvar l, i;
   generate
      for (l = 0; l < LANES; l++) begin : g_entry
         logic [31:0] phase;
         assign phase = (32'(ang[l]) & AMASK) << PSH;
         always_ff @(posedge clock) begin
            quad_ff[0][l] <= phase[31:30];
            x_ff[0][l]    <= CORDIC_X0;
            y_ff[0][l]    <= '0;
            z_ff[0][l]    <= Z_W'(phase[29:0]);
         end
      end

      for (i = 0; i < N; i++) begin : g_step
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[i+1] <= 1'b0;
            end else begin
               vld_ff[i+1] <= vld_ff[i];
            end
         end
         always_ff @(posedge clock) begin
            pay_ff[i+1] <= pay_ff[i];
         end
         for (l = 0; l < LANES; l++) begin : g_lane
            localparam logic signed [Z_W-1:0] ATN = Z_W'(atan_turn(5'(i)));
            always_ff @(posedge clock) begin
               quad_ff[i+1][l] <= quad_ff[i][l];
               if (!z_ff[i][l][Z_W-1]) begin
                  x_ff[i+1][l] <= x_ff[i][l] - (y_ff[i][l] >>> i);
                  y_ff[i+1][l] <= y_ff[i][l] + (x_ff[i][l] >>> i);
                  z_ff[i+1][l] <= z_ff[i][l] - ATN;
               end else begin
                  x_ff[i+1][l] <= x_ff[i][l] + (y_ff[i][l] >>> i);
                  y_ff[i+1][l] <= y_ff[i][l] - (x_ff[i][l] >>> i);
                  z_ff[i+1][l] <= z_ff[i][l] + ATN;
               end
            end
         end
      end
   endgenerate

   // Round to Q2.16, clamp to the unit range and unfold the quadrant
   logic signed [TRIG_W-1:0] sin_in [LANES], cos_in [LANES];
   logic signed [TRIG_W-1:0] sin_ff [LANES], cos_ff [LANES];
   logic                     vld_p_ff;
   req_type                  pay_p_ff;

   generate
      for (l = 0; l < LANES; l++) begin : g_post
         logic signed [XY_W-1:0]   xr, yr;
         logic signed [TRIG_W-1:0] c, s;
         always_comb begin
            xr = (x_ff[N][l] + XY_W'(8192)) >>> 14;
            yr = (y_ff[N][l] + XY_W'(8192)) >>> 14;
            if (xr > XY_W'(TRIG_ONE)) c = TRIG_ONE;
            else if (xr < -XY_W'(TRIG_ONE)) c = -TRIG_ONE;
            else c = TRIG_W'(xr);
            if (yr > XY_W'(TRIG_ONE)) s = TRIG_ONE;
            else if (yr < -XY_W'(TRIG_ONE)) s = -TRIG_ONE;
            else s = TRIG_W'(yr);
            unique case (quad_ff[N][l])
               2'd0: begin cos_in[l] = c;  sin_in[l] = s;  end
               2'd1: begin cos_in[l] = -s; sin_in[l] = c;  end
               2'd2: begin cos_in[l] = -c; sin_in[l] = -s; end
               default: begin cos_in[l] = s; sin_in[l] = -c; end
            endcase
         end
         always_ff @(posedge clock) begin
            sin_ff[l] <= sin_in[l];
            cos_ff[l] <= cos_in[l];
         end
      end
   endgenerate

   // Stage A: the two shared products
   logic signed [TRIG_W-1:0] a_sx_ff, a_cx_ff, a_sy_ff, a_cy_ff, a_sz_ff, a_cz_ff;
   logic signed [TRIG_W-1:0] a_szsx_ff, a_czsx_ff;
   logic                     vld_a_ff;
   req_type                  pay_a_ff;

   // Stage B: the rotation term products
   logic signed [TRIG_W-1:0] b_czcy_ff, b_szsxsy_ff, b_szcx_ff, b_szsxcy_ff, b_czsy_ff;
   logic signed [TRIG_W-1:0] b_czsxsy_ff, b_szcy_ff, b_czcx_ff, b_szsy_ff, b_czsxcy_ff;
   logic signed [TRIG_W-1:0] b_cxsy_ff, b_cxcy_ff, b_nsx_ff;
   logic                     vld_b_ff;
   req_type                  pay_b_ff;

   rot_type rot_in, rot_ff;
   logic    vld_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_p_ff <= 1'b0;
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
      end else begin
         vld_p_ff <= vld_ff[N];
         vld_a_ff <= vld_p_ff;
         vld_b_ff <= vld_a_ff;
         vld_c_ff <= vld_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      pay_p_ff  <= pay_ff[N];
      pay_a_ff  <= pay_p_ff;
      pay_b_ff  <= pay_a_ff;
      a_sx_ff   <= sin_ff[0];
      a_cx_ff   <= cos_ff[0];
      a_sy_ff   <= sin_ff[1];
      a_cy_ff   <= cos_ff[1];
      a_sz_ff   <= sin_ff[2];
      a_cz_ff   <= cos_ff[2];
      a_szsx_ff <= qmul_trig(sin_ff[2], sin_ff[0]);
      a_czsx_ff <= qmul_trig(cos_ff[2], sin_ff[0]);

      b_czcy_ff   <= qmul_trig(a_cz_ff, a_cy_ff);
      b_szsxsy_ff <= qmul_trig(a_szsx_ff, a_sy_ff);
      b_szcx_ff   <= qmul_trig(a_sz_ff, a_cx_ff);
      b_szsxcy_ff <= qmul_trig(a_szsx_ff, a_cy_ff);
      b_czsy_ff   <= qmul_trig(a_cz_ff, a_sy_ff);
      b_czsxsy_ff <= qmul_trig(a_czsx_ff, a_sy_ff);
      b_szcy_ff   <= qmul_trig(a_sz_ff, a_cy_ff);
      b_czcx_ff   <= qmul_trig(a_cz_ff, a_cx_ff);
      b_szsy_ff   <= qmul_trig(a_sz_ff, a_sy_ff);
      b_czsxcy_ff <= qmul_trig(a_czsx_ff, a_cy_ff);
      b_cxsy_ff   <= qmul_trig(a_cx_ff, a_sy_ff);
      b_cxcy_ff   <= qmul_trig(a_cx_ff, a_cy_ff);
      b_nsx_ff    <= -a_sx_ff;

      rot_ff <= rot_in;
   end

   always_comb begin
      rot_in.scale_x = pay_b_ff.scale_x;
      rot_in.scale_y = pay_b_ff.scale_y;
      rot_in.scale_z = pay_b_ff.scale_z;
      rot_in.move_x  = pay_b_ff.move_x;
      rot_in.move_y  = pay_b_ff.move_y;
      rot_in.move_z  = pay_b_ff.move_z;
      rot_in.r00     = ROT_W'(b_czcy_ff) + ROT_W'(b_szsxsy_ff);
      rot_in.r01     = ROT_W'(b_szcx_ff);
      rot_in.r02     = ROT_W'(b_szsxcy_ff) - ROT_W'(b_czsy_ff);
      rot_in.r10     = ROT_W'(b_czsxsy_ff) - ROT_W'(b_szcy_ff);
      rot_in.r11     = ROT_W'(b_czcx_ff);
      rot_in.r12     = ROT_W'(b_szsy_ff) + ROT_W'(b_czsxcy_ff);
      rot_in.r20     = ROT_W'(b_cxsy_ff);
      rot_in.r21     = ROT_W'(b_nsx_ff);
      rot_in.r22     = ROT_W'(b_cxcy_ff);
   end

   assign mid_push = vld_c_ff;
   assign mid_data = rot_ff;

endmodule

// File: design/trs_back.sv
// Back end: scales, saturates and queues a matrix row per cycle while there is room.
`timescale 1ns / 1ps

module trs_back import trs_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  rot_type mid_head,
   input  logic    mid_empty,
   output logic    mid_pop,
   output rsp_type rsp_data,
   output logic    empty,
   input  logic    pop
);

   localparam int OCW  = $clog2(OUT_DEPTH + 1);
   localparam int PW   = FIELD_W + ROT_W;
   localparam int WIDE = PW - 15;
   localparam int SW   = 50;
   localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

   rot_type        ent_ff;
   logic           have_ff, have_in;
   logic [1:0]     row_ff, row_in;
   logic [OCW-1:0] ocnt_ff, ocnt_in;
   logic           issue;
   logic           last_issue;

   logic signed [FIELD_W-1:0] k;
   logic signed [ROT_W-1:0]   ra, rb, rc;
   logic signed [WIDE-1:0]    e0_in, e1_in, e2_in, e3_in;
   logic signed [WIDE-1:0]    e0_ff, e1_ff, e2_ff, e3_ff;
   logic [1:0]                row1_ff;
   logic                      v1_ff;
   rsp_type                   out_in;

   function automatic logic signed [FIELD_W-1:0] sat_dw(input logic signed [WIDE-1:0] v);
      logic signed [SW-1:0] ve;
      logic signed [SW-1:0] r;
      ve = SW'(v);
      if (ve > SAT_HI) r = SAT_HI;
      else if (ve < SAT_LO) r = SAT_LO;
      else r = ve;
      return r[FIELD_W-1:0];
   endfunction

   function automatic logic signed [WIDE-1:0] qmul_row(input logic signed [FIELD_W-1:0] a,
                                                      input logic signed [ROT_W-1:0] b);
      logic signed [PW-1:0] p;
      p = PW'(a) * PW'(b);
      p = p + PW'(32768);
      return WIDE'(p >>> 16);
   endfunction

   // Hold a row slot back while the result queue has no room for it
   assign issue      = have_ff && (ocnt_ff != OCW'(OUT_DEPTH));
   assign last_issue = issue && (row_ff == 2'd3);
   assign mid_pop    = !mid_empty && (!have_ff || last_issue);

   always_comb begin
      if (mid_pop) have_in = 1'b1;
      else if (last_issue) have_in = 1'b0;
      else have_in = have_ff;
      row_in  = issue ? row_ff + 2'd1 : row_ff;
      ocnt_in = ocnt_ff + OCW'(issue) - OCW'(pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         row_ff  <= '0;
         ocnt_ff <= '0;
         v1_ff   <= 1'b0;
      end else begin
         have_ff <= have_in;
         row_ff  <= row_in;
         ocnt_ff <= ocnt_in;
         v1_ff   <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         ent_ff <= mid_head;
      end
   end

   always_comb begin
      unique case (row_ff)
         2'd0: begin k = ent_ff.scale_x; ra = ent_ff.r00; rb = ent_ff.r01; rc = ent_ff.r02; end
         2'd1: begin k = ent_ff.scale_y; ra = ent_ff.r10; rb = ent_ff.r11; rc = ent_ff.r12; end
         default: begin
            k = ent_ff.scale_z; ra = ent_ff.r20; rb = ent_ff.r21; rc = ent_ff.r22;
         end
      endcase
      if (row_ff == 2'd3) begin
         e0_in = WIDE'(ent_ff.move_x);
         e1_in = WIDE'(ent_ff.move_y);
         e2_in = WIDE'(ent_ff.move_z);
         e3_in = WIDE'(Q_ONE);
      end else begin
         e0_in = qmul_row(k, ra);
         e1_in = qmul_row(k, rb);
         e2_in = qmul_row(k, rc);
         e3_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff   <= e0_in;
      e1_ff   <= e1_in;
      e2_ff   <= e2_in;
      e3_ff   <= e3_in;
      row1_ff <= row_ff;
   end

   always_comb begin
      out_in.row_index = row1_ff;
      out_in.elem_0    = sat_dw(e0_ff);
      out_in.elem_1    = sat_dw(e1_ff);
      out_in.elem_2    = sat_dw(e2_ff);
      out_in.elem_3    = sat_dw(e3_ff);
      out_in.last_row  = (row1_ff == 2'd3);
   end

   trs_queue #(
      .T     (rsp_type),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (v1_ff),
      .push_data (out_in),
      .pop       (pop),
      .head      (rsp_data),
      .empty     (empty)
   );

endmodule

// File: design/trs_world_matrix_builder_top.sv
// An accepted request passes the front end, the middle queue and the back end before its first row
// result; the other rows follow. The back end's three row multipliers deliver one row per cycle
// while the result queue has room, and four rows make a request.
// The CORDIC and matrix front end is fully pipelined and takes a request each cycle
// while its 16-entry queue has credit. Reset is synchronous and active high; it
// empties all queues and pipelines and needs no clearing pass.
`timescale 1ns / 1ps

module trs_world_matrix_builder_top import trs_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    mid_push, mid_pop, mid_empty;
   rot_type mid_data, mid_head;

   trs_front #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .mid_pop  (mid_pop),
      .mid_push (mid_push),
      .mid_data (mid_data)
   );

   trs_queue #(
      .T     (rot_type),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_data),
      .pop       (mid_pop),
      .head      (mid_head),
      .empty     (mid_empty)
   );

   trs_back #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_head  (mid_head),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .rsp_data  (rsp_data),
      .empty     (empty),
      .pop       (pop)
   );

endmodule

// File: design/trs_checker.sv
// Port-level checker of the TRS world matrix builder and its bind to the top level.
`timescale 1ns / 1ps

module trs_checker import trs_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    push,
   input logic    full,
   input req_type req_data,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   logic [1:0] exp_row_ff;
   logic [7:0] pend_ff;

   // Track the expected row and the requests whose last row is still owed
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_row_ff <= '0;
         pend_ff    <= '0;
      end else begin
         if (pop && !empty) begin
            exp_row_ff <= exp_row_ff + 2'd1;
         end
         pend_ff <= pend_ff + 8'(push && !full) - 8'(pop && !empty && rsp_data.last_row);
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result side not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.row_index == exp_row_ff &&
                  rsp_data.last_row == (rsp_data.row_index == 2'd3)))
      else $error("row out of order or last flag wrong");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (pend_ff != 8'd0))
      else $error("result without an accepted request");

endmodule

bind trs_world_matrix_builder_top trs_checker u_checker (.*);

// File: bench/testbench.sv
// Self-checking bench for the TRS world matrix builder: random and corner transforms in, checked rows out.
`timescale 1ns / 1ps

module testbench;
   import trs_pkg::*;

   localparam int ITEM_COUNT = 470;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push  = 1'b0;
   logic    pop   = 1'b0;
   logic    full;
   logic    empty;
   req_type req_data = '0;
   rsp_type rsp_data;

   req_type pending_requests[$];
   rsp_type expected_rows[$];
   int      error_count    = 0;
   int      rows_checked   = 0;
   int      requests_sent  = 0;
   int      sender_idle    = 17;
   int      receiver_idle  = 55;
   int      hold_off       = 0;
   bit      hold_start     = 1'b0;
   bit      hold_used      = 1'b0;

   trs_world_matrix_builder_top DUT (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint fix_mul(longint a, longint b);
      return shr_floor(a * b + 32768, 16);
   endfunction

   function automatic logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint unit_clamp(longint v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
   endfunction

   // CORDIC on the binary angle, resolved to Q16.16 and folded by quadrant
   function automatic void sin_cos(input logic [15:0] angle, output longint s_out,
                                   output longint c_out);
      logic [31:0] phase;
      longint      x, y, z, dx, dy, c, s;
      phase = {angle, 16'd0};
      z = longint'(phase[29:0]);
      x = 652032874;
      y = 0;
      for (int i = 0; i < 28; i++) begin
         dx = shr_floor(y, i);
         dy = shr_floor(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_turn(5'(i)));
         end else begin
            x += dx; y -= dy; z += longint'(atan_turn(5'(i)));
         end
      end
      c = unit_clamp(shr_floor(x + 8192, 14));
      s = unit_clamp(shr_floor(y + 8192, 14));
      case (phase[31:30])
         2'd0: begin c_out = c;  s_out = s;  end
         2'd1: begin c_out = -s; s_out = c;  end
         2'd2: begin c_out = -c; s_out = -s; end
         default: begin c_out = s; s_out = -c; end
      endcase
   endfunction

   function automatic rsp_type make_row(logic [1:0] idx, longint e0, longint e1, longint e2,
                                        longint e3);
      rsp_type r;
      r.row_index = idx;
      r.elem_0    = sat32(e0);
      r.elem_1    = sat32(e1);
      r.elem_2    = sat32(e2);
      r.elem_3    = sat32(e3);
      r.last_row  = (idx == 2'd3);
      return r;
   endfunction

   task automatic predict_world_rows(req_type t);
      longint sx, cx, sy, cy, sz, cz, szsx, czsx, kx, ky, kz;
      sin_cos(t.angle_x, sx, cx);
      sin_cos(t.angle_y, sy, cy);
      sin_cos(t.angle_z, sz, cz);
      kx = t.scale_x; ky = t.scale_y; kz = t.scale_z;
      szsx = fix_mul(sz, sx);
      czsx = fix_mul(cz, sx);
      expected_rows.push_back(make_row(2'd0,
         fix_mul(kx, fix_mul(cz, cy) + fix_mul(szsx, sy)), fix_mul(kx, fix_mul(sz, cx)),
         fix_mul(kx, fix_mul(szsx, cy) - fix_mul(cz, sy)), 0));
      expected_rows.push_back(make_row(2'd1,
         fix_mul(ky, fix_mul(czsx, sy) - fix_mul(sz, cy)), fix_mul(ky, fix_mul(cz, cx)),
         fix_mul(ky, fix_mul(sz, sy) + fix_mul(czsx, cy)), 0));
      expected_rows.push_back(make_row(2'd2, fix_mul(kz, fix_mul(cx, sy)), fix_mul(kz, -sx),
         fix_mul(kz, fix_mul(cx, cy)), 0));
      expected_rows.push_back(make_row(2'd3, t.move_x, t.move_y, t.move_z, 65536));
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("row %0d: %s got %0d expected %0d", rows_checked, what, got, want);
   endtask

   function automatic logic [31:0] rand_q16();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
         2: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
         3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 256 * 65536)) - 128 * 65536);
      endcase
   endfunction

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 3)) << 14;
         1: return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 6)) - 16'd3;
         default: return 16'($urandom());
      endcase
   endfunction

   // Driver: offer the next queued request, hold it until accepted
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            predict_world_rows(req_data);
            requests_sent++;
            void'(pending_requests.pop_front());
         end
         if (pending_requests.size() > 0 && $urandom_range(0, 99) >= sender_idle) begin
            push     <= 1'b1;
            req_data <= pending_requests[0];
         end else if (!(push && full)) begin
            push <= 1'b0;
         end
      end
   end

   // Count down one long receiver stall once it has been asked for
   always @(posedge clock) begin
      if (hold_start && !hold_used) begin
         hold_off  <= 300;
         hold_used <= 1'b1;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
      end
   end

   // Monitor: check each popped row against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_rows.size() == 0) begin
               report_mismatch("unexpected row", rsp_data.row_index, -1);
            end else begin
               want = expected_rows.pop_front();
               if (rsp_data.row_index !== want.row_index)
                  report_mismatch("row_index", rsp_data.row_index, want.row_index);
               if (rsp_data.elem_0 !== want.elem_0)
                  report_mismatch("elem_0", rsp_data.elem_0, want.elem_0);
               if (rsp_data.elem_1 !== want.elem_1)
                  report_mismatch("elem_1", rsp_data.elem_1, want.elem_1);
               if (rsp_data.elem_2 !== want.elem_2)
                  report_mismatch("elem_2", rsp_data.elem_2, want.elem_2);
               if (rsp_data.elem_3 !== want.elem_3)
                  report_mismatch("elem_3", rsp_data.elem_3, want.elem_3);
               if (rsp_data.last_row !== want.last_row)
                  report_mismatch("last_row", rsp_data.last_row, want.last_row);
            end
            rows_checked++;
         end
         if (hold_off > 0) begin
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(0, 99) >= receiver_idle);
         end
      end
   end

   initial begin
      req_type t;
      logic [31:0] q_edges[4];
      q_edges = '{32'h7fffffff, 32'h80000000, 32'h00010000, 32'h00000000};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // corner transforms: saturating scales, quadrant angles, extreme moves
      for (int i = 0; i < 16; i++) begin
         t.scale_x = q_edges[i % 4];
         t.scale_y = q_edges[(i + 1) % 4];
         t.scale_z = q_edges[(i + 2) % 4];
         t.angle_x = 16'(i) << 14;
         t.angle_y = 16'((i + 1) % 4) << 14;
         t.angle_z = (i < 8) ? 16'hffff : 16'h2000;
         t.move_x  = q_edges[(i + 3) % 4];
         t.move_y  = ~q_edges[i % 4];
         t.move_z  = q_edges[(i / 4) % 4];
         pending_requests.push_back(t);
      end

      for (int i = 0; i < ITEM_COUNT - 16; i++) begin
         t.scale_x = rand_q16(); t.scale_y = rand_q16(); t.scale_z = rand_q16();
         t.angle_x = rand_angle(); t.angle_y = rand_angle(); t.angle_z = rand_angle();
         t.move_x  = $urandom(); t.move_y = $urandom(); t.move_z = $urandom();
         pending_requests.push_back(t);
      end

      // starve the output for a long stretch so the input backs up
      wait (requests_sent >= 20);
      hold_start = 1'b1;
      wait (requests_sent >= 150);
      sender_idle   = 55;
      receiver_idle = 17;
      wait (requests_sent >= 300);
      sender_idle   = 0;
      receiver_idle = 0;
      wait (pending_requests.size() == 0 && !push);
      wait (expected_rows.size() == 0);
      repeat (60) @(posedge clock);
      $display("%0d transforms sent, %0d rows checked, with stalls on both sides",
               requests_sent, rows_checked);
      if (error_count == 0)
         $display("trs_world_matrix_builder_top: match");
      else
         $display("trs_world_matrix_builder_top: mismatch");
      $finish;
   end

   initial begin
      #400000;
      $display("trs_world_matrix_builder_top: mismatch");
      $finish;
   end

endmodule
